// ===== rtl/core/dgw_pkg.sv =====
// Shared types, constants and helpers of the dependency graph width block.
package dgw_pkg;

  localparam int MaxNodes = 64;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int CntW     = IdxW + 1;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [MaxNodes-1:0] row_t;

  localparam logic REQ_EDGE    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef struct packed {
    logic we;
    idx_t waddr;
    row_t wmask;
    row_t wdata;
    idx_t raddr;
  } row_req_t;

  typedef struct packed {
    idx_t left;
    idx_t right;
  } frame_t;

  // lowest set bit of a nonzero row
  function automatic idx_t first_set(input row_t v);
    idx_t res;
    res = '0;
    for (int j = MaxNodes - 1; j >= 0; j--) begin
      if (v[j]) begin
        res = idx_t'(j);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/dgw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module dgw_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/dgw_row_mem.sv =====
// Adjacency row memory with per-bit write mask, used for edges then reachability.
module dgw_row_mem (
  input  logic              clk,
  input  dgw_pkg::row_req_t req,
  output dgw_pkg::row_t     rdata
);
  import dgw_pkg::*;

  row_t mem [MaxNodes];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= (mem[req.waddr] & ~req.wmask) | (req.wdata & req.wmask);
    end
    rdata <= mem[req.raddr];
  end
endmodule

// ===== rtl/core/dependency_graph_width.sv =====
// Top level: edge loading, transitive closure and matching sequencer.
// Usage:
//  cfg_*: write node_count (7 bits) while the block is idle.
//  in_*: one transfer per request. tuser = req_type. An edge request
//   (req_type 0) is taken while idle and sets one bit of the row memory;
//   edges are accepted back to back.
//  A compute request (req_type 1) runs the transitive closure in place in the
//   row memory for n active nodes (one row read-modify-write per cycle),
//   then an augmenting-path matching: each step is one row read or one
//   match/stack memory access.
//  One result then appears on out_*; the edge store is cleared after that by
//   a pass over all 64 rows, one row per cycle, during which in_tready is low.
//  Reset starts the same clearing pass; node_count resets to 0.
//  The result waits in an output register; a stalled receiver holds the
//   sequencer in its final state while an earlier result waits; none is lost.
module dependency_graph_width (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // from_node[5:0], to_node[11:6], zero pad
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // width[6:0], matching_size[13:7], zero pad
);
  import dgw_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CK   = 4'd2;
  localparam logic [3:0] S_CKL  = 4'd3;
  localparam logic [3:0] S_CI   = 4'd4;
  localparam logic [3:0] S_MST  = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_MAT  = 4'd7;
  localparam logic [3:0] S_POP  = 4'd8;
  localparam logic [3:0] S_AUG  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_r, state_nxt;
  cnt_t node_count_r;
  cnt_t n_r, n_nxt;
  idx_t k_r, k_nxt, i_r, i_nxt, left_r, left_nxt, u_r, u_nxt, r_r, r_nxt;
  cnt_t sp_r, sp_nxt, cnt_r, cnt_nxt;
  row_t rowk_r, rowk_nxt, vis_r, vis_nxt, vld_r, vld_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  row_req_t rreq;
  row_t     rrow;
  row_t     colmask, cand;
  idx_t     m_waddr, m_raddr, m_wdata, m_rdata;
  logic     m_we;
  cnt_t     s_waddr, s_raddr;
  frame_t   s_wdata, s_rdata;
  logic     s_we;
  cnt_t     wid;

  dgw_row_mem u_rows (.clk(clk), .req(rreq), .rdata(rrow));

  dgw_ram #(.Width(IdxW), .Depth(MaxNodes)) u_match (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata));

  dgw_ram #(.Width($bits(frame_t)), .Depth(MaxNodes)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr[IdxW-1:0]), .wdata(s_wdata),
    .raddr(s_raddr[IdxW-1:0]), .rdata(s_rdata));

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int j = 0; j < MaxNodes; j++) begin
      colmask[j] = (CntW'(j) < n_r);
    end
  end

  assign cand = rrow & colmask & ~vis_r;
  assign wid  = (n_r > cnt_r) ? (n_r - cnt_r) : cnt_t'(1);

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; k_nxt = k_r; i_nxt = i_r; left_nxt = left_r;
    u_nxt = u_r; r_nxt = r_r; sp_nxt = sp_r; cnt_nxt = cnt_r;
    rowk_nxt = rowk_r; vis_nxt = vis_r; vld_nxt = vld_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rreq = '{we: 1'b0, waddr: '0, wmask: '0, wdata: '0, raddr: '0};
    m_we = 1'b0; m_waddr = r_r; m_wdata = u_r; m_raddr = '0;
    s_we = 1'b0; s_waddr = sp_r; s_wdata = '{left: u_r, right: r_r}; s_raddr = sp_r - 1'b1;
    case (state_r)
      S_CLR: begin
        rreq.we = 1'b1; rreq.waddr = i_r; rreq.wmask = '1;
        i_nxt = i_r + 1'b1;
        if (i_r == idx_t'(MaxNodes - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == REQ_EDGE) begin
            rreq.we = 1'b1; rreq.waddr = in_tdata[5:0];
            rreq.wmask = row_t'(1) << in_tdata[11:6]; rreq.wdata = '1;
          end else begin
            n_nxt = (node_count_r > cnt_t'(MaxNodes)) ? cnt_t'(MaxNodes) : node_count_r;
            k_nxt = '0; cnt_nxt = '0; left_nxt = '0; vld_nxt = '0;
            state_nxt = (n_nxt == '0) ? S_DONE : S_CK;
          end
        end
      end
      S_CK: begin
        rreq.raddr = k_r;
        state_nxt = S_CKL;
      end
      S_CKL: begin
        rowk_nxt = rrow; i_nxt = '0; rreq.raddr = '0;
        state_nxt = S_CI;
      end
      S_CI: begin
        rreq.we = rrow[k_r]; rreq.waddr = i_r; rreq.wmask = '1;
        rreq.wdata = rrow | rowk_r;
        if ({1'b0, i_r} + 1'b1 == n_r) begin
          if ({1'b0, k_r} + 1'b1 == n_r) begin
            state_nxt = S_MST;
          end else begin
            k_nxt = k_r + 1'b1; state_nxt = S_CK;
          end
        end else begin
          i_nxt = i_r + 1'b1; rreq.raddr = i_r + 1'b1;
        end
      end
      S_MST: begin
        u_nxt = left_r; vis_nxt = '0; sp_nxt = '0; rreq.raddr = left_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cand != '0) begin
          r_nxt = first_set(cand);
          vis_nxt[r_nxt] = 1'b1;
          m_raddr = r_nxt;
          state_nxt = S_MAT;
        end else if (sp_r == '0) begin
          if ({1'b0, left_r} + 1'b1 == n_r) state_nxt = S_DONE;
          else begin
            left_nxt = left_r + 1'b1; state_nxt = S_MST;
          end
        end else begin
          state_nxt = S_POP;
        end
      end
      S_MAT: begin
        if (!vld_r[r_r]) begin
          m_we = 1'b1; vld_nxt[r_r] = 1'b1;
          if (sp_r == '0) begin
            cnt_nxt = cnt_r + 1'b1;
            if ({1'b0, left_r} + 1'b1 == n_r) state_nxt = S_DONE;
            else begin
              left_nxt = left_r + 1'b1; state_nxt = S_MST;
            end
          end else begin
            state_nxt = S_AUG;
          end
        end else begin
          s_we = 1'b1; sp_nxt = sp_r + 1'b1;
          u_nxt = m_rdata; rreq.raddr = m_rdata;
          state_nxt = S_SCAN;
        end
      end
      S_POP: begin
        u_nxt = s_rdata.left; sp_nxt = sp_r - 1'b1; rreq.raddr = s_rdata.left;
        state_nxt = S_SCAN;
      end
      S_AUG: begin
        m_we = 1'b1; m_waddr = s_rdata.right; m_wdata = s_rdata.left;
        vld_nxt[s_rdata.right] = 1'b1;
        sp_nxt = sp_r - 1'b1; s_raddr = sp_r - 2'd2;
        if (sp_r == cnt_t'(1)) begin
          cnt_nxt = cnt_r + 1'b1;
          if ({1'b0, left_r} + 1'b1 == n_r) state_nxt = S_DONE;
          else begin
            left_nxt = left_r + 1'b1; state_nxt = S_MST;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, cnt_r, wid};
          i_nxt = '0; state_nxt = S_CLR;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; i_r <= '0; node_count_r <= '0;
      out_valid_r <= 1'b0; sp_r <= '0; cnt_r <= '0; vld_r <= '0; n_r <= '0;
    end else begin
      state_r <= state_nxt; i_r <= i_nxt; out_valid_r <= out_valid_nxt;
      sp_r <= sp_nxt; cnt_r <= cnt_nxt; vld_r <= vld_nxt; n_r <= n_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt; left_r <= left_nxt; u_r <= u_nxt; r_r <= r_nxt;
    rowk_r <= rowk_nxt; vis_r <= vis_nxt; out_data_r <= out_data_nxt;
  end

  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_tready) else $error("input taken during clear");
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r < cnt_t'(MaxNodes)) else $error("search stack overflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= n_r) else $error("matching larger than node count");
  a_vld_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MST |-> $countones(vld_r) == int'(cnt_r))
    else $error("match valid bits disagree with count");
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !out_valid_r |=> out_valid_r && state_r == S_CLR)
    else $error("result not loaded");

endmodule
